/* sv/thread_scheduler_with_semaphores_core_defines.svh */
// Assertion macros for the thread scheduler core.
// Used by the top level only; the macros expect clk and arst_n in scope.
`ifndef THREAD_SCHEDULER_WITH_SEMAPHORES_CORE_DEFINES_SVH
`define THREAD_SCHEDULER_WITH_SEMAPHORES_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/tss_pkg.sv */
// Shared constants, codes and types of the thread scheduler core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

	// Sizes of the thread ring, event set and semaphore set.
	localparam int THREADS         = 6;
	localparam int PERIODIC_EVENTS = 2;
	localparam int SEMAPHORES      = 4;

	localparam int THR_W     = $clog2(THREADS);
	localparam int STEP_W    = $clog2(THREADS + 1);
	localparam int SEM_IDX_W = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;

	// Field widths of the command and result words.
	localparam int MODE_W   = 3;
	localparam int TIME_W   = 16;
	localparam int SEM_ID_W = 2;
	localparam int COUNT_W  = 16;
	localparam int RUN_W    = 3;
	localparam int FIRED_W  = 2;
	localparam int EVCNT_W  = 2;
	localparam int REG_IDX_W  = 2;
	localparam int REG_DATA_W = 16;

	// Operation codes.
	localparam logic [MODE_W-1:0] MODE_SLICE  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TICK   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SLEEP  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_WAIT   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SIGNAL = 3'd4;
	localparam logic [MODE_W-1:0] MODE_INIT   = 3'd5;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_EVENT_PERIOD_ZERO = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_EVENT_PERIOD_ONE  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_EVENT_COUNT       = 2'd2;

	// Saturation limits of a semaphore count.
	localparam logic signed [COUNT_W-1:0] SEM_MIN = 16'sh8000;
	localparam logic signed [COUNT_W-1:0] SEM_MAX = 16'sh7fff;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic step;
	} tss_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_search;
		logic search_done;
	} tss_status_t;

endpackage

`default_nettype wire

/* sv/tss_ctrl.sv */
// Controller state machine of the thread scheduler core.
// Depends on tss_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module tss_ctrl
	import tss_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire tss_status_t status,
	output tss_cmd_t    cmd,
	output logic        busy,
	output logic        done
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_SEARCH = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;

	// Next state and command decode.
	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load   = 1'b1;
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec   = 1'b1;
				state_next = status.need_search ? ST_SEARCH : ST_DONE;
			end
			ST_SEARCH: begin
				cmd.step = 1'b1;
				if (status.search_done) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

`default_nettype wire

/* sv/tss_datapath.sv */
// Datapath of the thread scheduler core: thread, semaphore and event state,
// the ring search unit and the result word. Depends on tss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tss_datapath
	import tss_pkg::*;
(
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire tss_cmd_t                cmd,
	output tss_status_t                  status,
	input  wire  [MODE_W-1:0]            mode,
	input  wire  [TIME_W-1:0]            sleep_time,
	input  wire  [SEM_ID_W-1:0]          semaphore_id,
	input  wire  signed [COUNT_W-1:0]    semaphore_value,
	input  wire                          wr_en,
	input  wire  [REG_IDX_W-1:0]         wr_index,
	input  wire  [REG_DATA_W-1:0]        wr_data,
	output logic [RUN_W-1:0]             running_thread,
	output logic                         none_ready,
	output logic                         caller_blocked,
	output logic                         woken_valid,
	output logic [RUN_W-1:0]             woken_thread,
	output logic                         signal_unmatched,
	output logic [FIRED_W-1:0]           fired_events,
	output logic signed [COUNT_W-1:0]    semaphore_count
);

	// Scheduler state.
	logic [THR_W-1:0]              run_q;
	logic [TIME_W-1:0]             sleep_q   [THREADS];
	logic                          blk_q     [THREADS];
	logic [SEM_ID_W-1:0]           blk_on_q  [THREADS];
	logic signed [COUNT_W-1:0]     sem_q     [SEMAPHORES];
	logic [REG_DATA_W-1:0]         cd_q      [PERIODIC_EVENTS];
	logic [REG_DATA_W-1:0]         per_q     [PERIODIC_EVENTS];
	logic [EVCNT_W-1:0]            evcnt_q;

	// Latched command word.
	logic [MODE_W-1:0]             mode_q;
	logic [TIME_W-1:0]             stime_q;
	logic [SEM_ID_W-1:0]           sid_q;
	logic signed [COUNT_W-1:0]     sval_q;

	// Ring search unit.
	logic [THR_W-1:0]              cand_q;
	logic [STEP_W-1:0]             step_q;
	logic                          kind_q;

	// Result word.
	logic                          res_none_q;
	logic                          res_blk_q;
	logic                          res_wv_q;
	logic [THR_W-1:0]              res_woken_q;
	logic                          res_unm_q;
	logic [PERIODIC_EVENTS-1:0]    res_fired_q;
	logic signed [COUNT_W-1:0]     res_cnt_q;

	logic                          sid_ok;
	logic [SEM_IDX_W-1:0]          sidx;
	logic signed [COUNT_W-1:0]     cur_cnt;
	logic signed [COUNT_W-1:0]     wait_cnt;
	logic signed [COUNT_W-1:0]     sig_cnt;
	logic                          wait_blocks;
	logic                          sig_wakes;
	logic [THR_W-1:0]              first_cand;
	logic [THR_W-1:0]              next_cand;
	logic                          cand_hit;
	logic                          last_step;
	logic [PERIODIC_EVENTS-1:0]    ev_active;
	logic [PERIODIC_EVENTS-1:0]    fired_next;

	// Semaphore arithmetic on the addressed count, saturating both ways.
	always_comb begin
		sid_ok      = (32'(sid_q) < SEMAPHORES);
		sidx        = SEM_IDX_W'(sid_q);
		cur_cnt     = sem_q[sidx];
		wait_cnt    = (cur_cnt == SEM_MIN) ? cur_cnt : cur_cnt - 16'sd1;
		sig_cnt     = (cur_cnt == SEM_MAX) ? cur_cnt : cur_cnt + 16'sd1;
		wait_blocks = sid_ok && (wait_cnt < 16'sd0);
		sig_wakes   = sid_ok && (sig_cnt <= 16'sd0);
	end

	// Which operations go on to a ring search, and one ring candidate per
	// cycle: a runnable thread, or a waiter on sid_q.
	always_comb begin
		case (mode_q)
			MODE_SLICE:  status.need_search = 1'b1;
			MODE_SLEEP:  status.need_search = 1'b1;
			MODE_WAIT:   status.need_search = wait_blocks;
			MODE_SIGNAL: status.need_search = sig_wakes;
			default:     status.need_search = 1'b0;
		endcase
		first_cand = (run_q == THR_W'(THREADS - 1)) ? '0 : run_q + THR_W'(1);
		next_cand  = (cand_q == THR_W'(THREADS - 1)) ? '0 : cand_q + THR_W'(1);
		if (kind_q) begin
			cand_hit = blk_q[cand_q] && (blk_on_q[cand_q] == sid_q);
		end else begin
			cand_hit = !blk_q[cand_q] && (sleep_q[cand_q] == '0);
		end
		last_step          = (step_q == STEP_W'(THREADS));
		status.search_done = cand_hit || last_step;
	end

	// Events that are in use, and those that fire on a tick.
	always_comb begin
		for (int e = 0; e < PERIODIC_EVENTS; e++) begin
			ev_active[e]  = (32'(evcnt_q) > e);
			fired_next[e] = ev_active[e] && (cd_q[e] == '0);
		end
	end

	// Scheduler state, configuration and per-operation updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			evcnt_q <= '0;
			for (int t = 0; t < THREADS; t++) begin
				sleep_q[t]  <= '0;
				blk_q[t]    <= 1'b0;
				blk_on_q[t] <= '0;
			end
			for (int s = 0; s < SEMAPHORES; s++) begin
				sem_q[s] <= '0;
			end
			for (int e = 0; e < PERIODIC_EVENTS; e++) begin
				cd_q[e]  <= '0;
				per_q[e] <= '0;
			end
		end else begin
			// Configuration writes; a period write also reloads its countdown.
			if (wr_en) begin
				for (int e = 0; e < PERIODIC_EVENTS; e++) begin
					if (e < 2 && wr_index == REG_IDX_W'(e)) begin
						per_q[e] <= wr_data;
						cd_q[e]  <= wr_data;
					end
				end
				if (wr_index == REG_EVENT_COUNT) begin
					evcnt_q <= wr_data[EVCNT_W-1:0];
				end
			end

			// Execute step of an operation, after its command word is latched.
			if (cmd.exec) begin
				case (mode_q)
					MODE_TICK: begin
						for (int t = 0; t < THREADS; t++) begin
							if (sleep_q[t] != '0) begin
								sleep_q[t] <= sleep_q[t] - TIME_W'(1);
							end
						end
						for (int e = 0; e < PERIODIC_EVENTS; e++) begin
							if (ev_active[e]) begin
								if (cd_q[e] != '0) begin
									cd_q[e] <= cd_q[e] - REG_DATA_W'(1);
								end else begin
									cd_q[e] <= per_q[e];
								end
							end
						end
					end
					MODE_SLEEP: begin
						sleep_q[run_q] <= stime_q;
					end
					MODE_WAIT: begin
						if (sid_ok) begin
							sem_q[sidx] <= wait_cnt;
						end
						if (wait_blocks) begin
							blk_q[run_q]    <= 1'b1;
							blk_on_q[run_q] <= sid_q;
						end
					end
					MODE_SIGNAL: begin
						if (sid_ok) begin
							sem_q[sidx] <= sig_cnt;
						end
					end
					MODE_INIT: begin
						if (sid_ok) begin
							sem_q[sidx] <= sval_q;
						end
					end
					default: begin
					end
				endcase
			end

			// A hit ends the search: switch threads or release the waiter.
			if (cmd.step && cand_hit) begin
				if (kind_q) begin
					blk_q[cand_q] <= 1'b0;
				end else begin
					run_q <= cand_q;
				end
			end
		end
	end

	// Command word, search unit and result word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			stime_q <= sleep_time;
			sid_q   <= semaphore_id;
			sval_q  <= semaphore_value;
		end

		if (cmd.exec) begin
			cand_q      <= first_cand;
			step_q      <= STEP_W'(1);
			kind_q      <= (mode_q == MODE_SIGNAL);
			res_none_q  <= 1'b0;
			res_wv_q    <= 1'b0;
			res_woken_q <= '0;
			res_unm_q   <= 1'b0;
			res_blk_q   <= (mode_q == MODE_WAIT) && wait_blocks;
			res_fired_q <= (mode_q == MODE_TICK) ? fired_next : '0;
			case (mode_q)
				MODE_WAIT:   res_cnt_q <= sid_ok ? wait_cnt : '0;
				MODE_SIGNAL: res_cnt_q <= sid_ok ? sig_cnt : '0;
				MODE_INIT:   res_cnt_q <= sid_ok ? sval_q : '0;
				default:     res_cnt_q <= '0;
			endcase
		end

		if (cmd.step) begin
			if (cand_hit) begin
				if (kind_q) begin
					res_wv_q    <= 1'b1;
					res_woken_q <= cand_q;
				end
			end else begin
				cand_q <= next_cand;
				step_q <= step_q + STEP_W'(1);
				if (last_step) begin
					if (kind_q) begin
						res_unm_q <= 1'b1;
					end else begin
						res_none_q <= 1'b1;
					end
				end
			end
		end
	end

	assign running_thread   = RUN_W'(run_q);
	assign none_ready       = res_none_q;
	assign caller_blocked   = res_blk_q;
	assign woken_valid      = res_wv_q;
	assign woken_thread     = RUN_W'(res_woken_q);
	assign signal_unmatched = res_unm_q;
	assign fired_events     = FIRED_W'(res_fired_q);
	assign semaphore_count  = res_cnt_q;

endmodule

`default_nettype wire

/* sv/thread_scheduler_with_semaphores_core.sv */
// Top level of the thread scheduler core: controller plus datapath.
// Depends on tss_pkg, tss_ctrl, tss_datapath and the assertion header.
//
// Round-robin scheduler for a ring of six threads with four counting
// semaphores and two periodic events. An operation is taken when start is
// high and busy is low; its result word appears on the result ports for
// exactly one cycle with done high, and must be captured then, since the
// receiver cannot stall the block. One operation is in flight at a time.
// Tick, semaphore init and operations that need no reschedule go through
// the exec and done states; a slice, a sleep, a blocking wait or a signal
// that may wake a waiter also takes the search state, where the ring search
// checks one candidate thread per cycle, up to every thread. busy falls in
// the cycle after done. Registers are to be written with wr_en only while
// the block is idle, which the block does not enforce; they take effect at once.
`timescale 1ns / 1ps
`default_nettype none

`include "thread_scheduler_with_semaphores_core_defines.svh"

module thread_scheduler_with_semaphores_core
	import tss_pkg::*;
(
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  [MODE_W-1:0]            mode,
	input  wire  [TIME_W-1:0]            sleep_time,
	input  wire  [SEM_ID_W-1:0]          semaphore_id,
	input  wire  signed [COUNT_W-1:0]    semaphore_value,
	input  wire                          wr_en,
	input  wire  [REG_IDX_W-1:0]         wr_index,
	input  wire  [REG_DATA_W-1:0]        wr_data,
	output logic                         done,
	output logic [RUN_W-1:0]             running_thread,
	output logic                         none_ready,
	output logic                         caller_blocked,
	output logic                         woken_valid,
	output logic [RUN_W-1:0]             woken_thread,
	output logic                         signal_unmatched,
	output logic [FIRED_W-1:0]           fired_events,
	output logic signed [COUNT_W-1:0]    semaphore_count
);

	tss_cmd_t    cmd;
	tss_status_t status;

	// Sequencer.
	tss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// State, search unit and result word.
	tss_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.mode             (mode),
		.sleep_time       (sleep_time),
		.semaphore_id     (semaphore_id),
		.semaphore_value  (semaphore_value),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.running_thread   (running_thread),
		.none_ready       (none_ready),
		.caller_blocked   (caller_blocked),
		.woken_valid      (woken_valid),
		.woken_thread     (woken_thread),
		.signal_unmatched (signal_unmatched),
		.fired_events     (fired_events),
		.semaphore_count  (semaphore_count)
	);

	// An accepted operation keeps the block busy and has no result yet.
	`TSS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept did not raise busy")
	// Each operation gives exactly one result word.
	`TSS_ASSERT_NEXT(a_single_done, done, !done, "done held for more than one cycle")
	// A blocking wait leaves a negative count and wakes nobody.
	`TSS_ASSERT_NOW(a_blocked_count, done && caller_blocked,
		semaphore_count < 16'sd0 && !woken_valid, "blocked caller with bad count")
	// A wakeup only happens on a count at or below zero.
	`TSS_ASSERT_NOW(a_woken_count, done && woken_valid,
		semaphore_count <= 16'sd0 && !signal_unmatched, "wakeup with bad count")

endmodule

`default_nettype wire
